### rtl/core/polyphonic_voice_allocator_top_assert.svh
// ----------------------------------------------------------------------------
// Polyphonic voice allocator assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef POLYPHONIC_VOICE_ALLOCATOR_TOP_ASSERT_SVH
`define POLYPHONIC_VOICE_ALLOCATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PVA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PVA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg
// Types and constants shared by the voice allocator cells and top level.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int NUM_SLOTS_DEF = 32;
  localparam int SLOT_W        = 5;
  localparam int NOTE_W        = 7;
  localparam int VEL_W         = 7;
  localparam int MASK_W        = 32;

  typedef enum logic [1:0] {
    OP_NOTE_ON    = 2'd0,
    OP_NOTE_OFF   = 2'd1,
    OP_VOICE_DONE = 2'd2
  } op_t;

  // What the search token does as it passes each cell.
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ON   = 2'd1,
    KIND_OFF  = 2'd2,
    KIND_DONE = 2'd3
  } kind_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [NOTE_W-1:0] note;
    logic [SLOT_W-1:0] slot;
    logic              done;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              rel_found;
    logic [SLOT_W-1:0] rel_idx;
    logic [NOTE_W-1:0] rel_note;
    logic [NOTE_W-1:0] zero_note;
    logic [MASK_W-1:0] mask;
  } token_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    logic [NOTE_W-1:0] note;
  } wr_t;

endpackage

### rtl/core/pva_cell.sv
// ----------------------------------------------------------------------------
// pva_cell
// One voice slot. Updates its slot as the token passes and hands the token on.
// ----------------------------------------------------------------------------
module pva_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [pva_pkg::SLOT_W-1:0]  idx,
  input  pva_pkg::token_t             tok_in,
  input  pva_pkg::wr_t                wr,
  output pva_pkg::token_t             tok_out
);

  logic                       busy;
  logic                       releasing;
  logic [pva_pkg::NOTE_W-1:0] slot_note;

  logic            held;
  logic            rel_set;
  logic            clr;
  pva_pkg::token_t tok_next;

  assign held = busy && !releasing && (slot_note == tok_in.note);

  always_comb begin
    tok_next = tok_in;
    rel_set  = 1'b0;
    clr      = 1'b0;
    if (tok_in.valid) begin
      case (tok_in.kind)
        pva_pkg::KIND_ON: begin
          rel_set = held;
          if (!busy && !tok_in.free_found) begin
            tok_next.free_found = 1'b1;
            tok_next.free_idx   = idx;
          end
          // A slot released by this same item already counts as releasing.
          if ((releasing || held) && !tok_in.rel_found) begin
            tok_next.rel_found = 1'b1;
            tok_next.rel_idx   = idx;
            tok_next.rel_note  = slot_note;
          end
          if (idx == '0) begin
            tok_next.zero_note = slot_note;
          end
        end
        pva_pkg::KIND_OFF: begin
          if (held && !tok_in.done) begin
            rel_set       = 1'b1;
            tok_next.done = 1'b1;
          end
        end
        pva_pkg::KIND_DONE: begin
          clr = (tok_in.slot == idx);
        end
        default: begin
        end
      endcase
    end
    if (rel_set) begin
      tok_next.mask = tok_in.mask | (pva_pkg::MASK_W'(1) << idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      releasing <= 1'b0;
      slot_note <= '0;
      tok_out   <= '0;
    end else begin
      tok_out <= tok_next;
      if (wr.en && (wr.idx == idx)) begin
        busy      <= 1'b1;
        releasing <= 1'b0;
        slot_note <= wr.note;
      end else if (clr) begin
        busy      <= 1'b0;
        releasing <= 1'b0;
        slot_note <= '0;
      end else if (rel_set) begin
        releasing <= 1'b1;
      end
    end
  end

endmodule

### rtl/core/polyphonic_voice_allocator_top.sv
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator_top
// Voice slot allocator with stealing, built as a row of slot cells.
// ----------------------------------------------------------------------------
// Events are taken one at a time. A search token is launched into a register
// and then walks down the row of cells, each of which registers it, releasing
// matching voices and noting the first free and first releasing slot. The
// chosen slot is then settled into the pending registers and moved into the
// output register once that is free. The result register may still be
// waiting to be taken while the next event is already running.
module polyphonic_voice_allocator_top #(
  parameter int NUM_SLOTS = pva_pkg::NUM_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  operation,
  input  logic [pva_pkg::NOTE_W-1:0]  note,
  input  logic [pva_pkg::VEL_W-1:0]   velocity,
  input  logic [pva_pkg::SLOT_W-1:0]  slot,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        assigned,
  output logic [pva_pkg::SLOT_W-1:0]  assigned_slot,
  output logic                        replaced,
  output logic [pva_pkg::NOTE_W-1:0]  replaced_note,
  output logic [pva_pkg::MASK_W-1:0]  release_mask
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  pva_pkg::token_t tok_head;
  pva_pkg::token_t tok_launch;
  pva_pkg::token_t chain [NUM_SLOTS+1];
  pva_pkg::token_t tail;
  pva_pkg::wr_t    wr;

  logic                       in_accept;
  logic                       out_free;
  logic                       tail_done;
  pva_pkg::kind_t             kind_in;

  logic                       res_assigned;
  logic [pva_pkg::SLOT_W-1:0] res_slot;
  logic                       res_replaced;
  logic [pva_pkg::NOTE_W-1:0] res_note;

  logic                       pend_assigned;
  logic [pva_pkg::SLOT_W-1:0] pend_slot;
  logic                       pend_replaced;
  logic [pva_pkg::NOTE_W-1:0] pend_note;
  logic [pva_pkg::MASK_W-1:0] pend_mask;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign chain[0]  = tok_head;
  assign tail      = chain[NUM_SLOTS];
  assign tail_done = (state == S_RUN) && tail.valid;

  // A note on with zero velocity behaves as a note off.
  always_comb begin
    unique case (operation)
      pva_pkg::OP_NOTE_ON:    kind_in = (velocity != '0) ? pva_pkg::KIND_ON
                                                         : pva_pkg::KIND_OFF;
      pva_pkg::OP_NOTE_OFF:   kind_in = pva_pkg::KIND_OFF;
      pva_pkg::OP_VOICE_DONE: kind_in = pva_pkg::KIND_DONE;
      default:                kind_in = pva_pkg::KIND_NONE;
    endcase
  end

  always_comb begin
    tok_launch       = '0;
    tok_launch.valid = 1'b1;
    tok_launch.kind  = kind_in;
    tok_launch.note  = note;
    tok_launch.slot  = slot;
  end

  genvar gi;
  generate
    for (gi = 0; gi < NUM_SLOTS; gi++) begin : g_cell
      pva_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .idx     (pva_pkg::SLOT_W'(gi)),
        .tok_in  (chain[gi]),
        .wr      (wr),
        .tok_out (chain[gi+1])
      );
    end
  endgenerate

  // Slot choice: first free, else first releasing, else slot 0.
  always_comb begin
    res_assigned = 1'b0;
    res_slot     = '0;
    res_replaced = 1'b0;
    res_note     = '0;
    if (tail.kind == pva_pkg::KIND_ON) begin
      res_assigned = 1'b1;
      if (tail.free_found) begin
        res_slot = tail.free_idx;
      end else begin
        res_replaced = 1'b1;
        if (tail.rel_found) begin
          res_slot = tail.rel_idx;
          res_note = tail.rel_note;
        end else begin
          res_note = tail.zero_note;
        end
      end
    end
    wr.en   = tail_done && (tail.kind == pva_pkg::KIND_ON);
    wr.idx  = res_slot;
    wr.note = tail.note;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_accept) state_next = S_RUN;
      S_RUN:  if (tail.valid) state_next = S_HOLD;
      S_HOLD: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tok_head  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_accept) begin
        tok_head <= tok_launch;
      end else begin
        tok_head.valid <= 1'b0;
      end
      if ((state == S_HOLD) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail_done) begin
      pend_assigned <= res_assigned;
      pend_slot     <= res_slot;
      pend_replaced <= res_replaced;
      pend_note     <= res_note;
      pend_mask     <= tail.mask;
    end
    if ((state == S_HOLD) && out_free) begin
      assigned      <= pend_assigned;
      assigned_slot <= pend_slot;
      replaced      <= pend_replaced;
      replaced_note <= pend_note;
      release_mask  <= pend_mask;
    end
  end

`include "polyphonic_voice_allocator_top_assert.svh"

  `PVA_ASSERT_NEXT(a_accept_runs, in_accept, state == S_RUN, "accepted item did not start a search")
  `PVA_ASSERT_SAME(a_tail_in_run, tail.valid, state == S_RUN, "token left the row outside a search")
  `PVA_ASSERT_SAME(a_write_onehot, wr.en, tail.valid && (tail.kind == pva_pkg::KIND_ON), "slot written without a note on")
  `PVA_ASSERT_SAME(a_replaced_assigned, out_valid && replaced, assigned, "voice cut off without a new assignment")

endmodule

### test/polyphonic_voice_allocator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator_top_tb
// Drives note on, note off and voice finished items into the allocator with
// random gaps on both sides and two long output hold-offs. A slot table kept
// in the testbench predicts each result, which is compared field by field.
// ----------------------------------------------------------------------------
module polyphonic_voice_allocator_top_tb;

  localparam int         SLOTS        = pva_pkg::NUM_SLOTS_DEF;
  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         RANDOM_ITEMS = 800;
  localparam int         IDLE_LIMIT   = 4000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         DRAIN_CYCLES = 80;
  localparam int         REPORT_MAX   = 10;

  typedef struct packed {
    logic                       assigned;
    logic [pva_pkg::SLOT_W-1:0] aslot;
    logic                       replaced;
    logic [pva_pkg::NOTE_W-1:0] rnote;
    logic [pva_pkg::MASK_W-1:0] mask;
  } outcome_t;

  class voice_alloc_tracker;
    logic                       busy   [SLOTS];
    logic [pva_pkg::NOTE_W-1:0] tone   [SLOTS];
    logic                       fading [SLOTS];
    outcome_t                   pending_outcomes[$];
    int                         errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        busy[i]   = 1'b0;
        tone[i]   = '0;
        fading[i] = 1'b0;
      end
      errors = 0;
    endfunction

    function bit is_sounding(int i, logic [pva_pkg::NOTE_W-1:0] nt);
      return busy[i] && !fading[i] && tone[i] == nt;
    endfunction

    function outcome_t predict_outcome(logic [1:0] op, logic [pva_pkg::NOTE_W-1:0] nt,
                                       logic [pva_pkg::VEL_W-1:0] vel,
                                       logic [pva_pkg::SLOT_W-1:0] sl);
      outcome_t o;
      int       pick;
      bit       found;
      o     = '0;
      pick  = 0;
      found = 1'b0;
      if (op == pva_pkg::OP_NOTE_ON && vel != 0) begin
        // A retriggered note releases every held copy before a slot is chosen.
        for (int i = 0; i < SLOTS; i++) begin
          if (is_sounding(i, nt)) begin
            fading[i] = 1'b1;
            o.mask[i] = 1'b1;
          end
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && !busy[i]) begin
            pick  = i;
            found = 1'b1;
          end
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && fading[i]) begin
            pick  = i;
            found = 1'b1;
          end
        end
        if (busy[pick]) begin
          o.replaced = 1'b1;
          o.rnote    = tone[pick];
        end
        busy[pick]   = 1'b1;
        tone[pick]   = nt;
        fading[pick] = 1'b0;
        o.assigned   = 1'b1;
        o.aslot      = pva_pkg::SLOT_W'(pick);
      end else if (op == pva_pkg::OP_NOTE_ON || op == pva_pkg::OP_NOTE_OFF) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && is_sounding(i, nt)) begin
            fading[i] = 1'b1;
            o.mask[i] = 1'b1;
            found     = 1'b1;
          end
        end
      end else if (op == pva_pkg::OP_VOICE_DONE) begin
        if (sl < SLOTS) begin
          busy[sl]   = 1'b0;
          tone[sl]   = '0;
          fading[sl] = 1'b0;
        end
      end
      return o;
    endfunction

    function void note_event(logic [1:0] op, logic [pva_pkg::NOTE_W-1:0] nt,
                             logic [pva_pkg::VEL_W-1:0] vel,
                             logic [pva_pkg::SLOT_W-1:0] sl);
      pending_outcomes.push_back(predict_outcome(op, nt, vel, sl));
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("Unexpected result: assigned=%0d slot=%0d replaced=%0d note=%0d mask=%h",
                   got.assigned, got.aslot, got.replaced, got.rnote, got.mask);
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.assigned !== want.assigned || got.aslot !== want.aslot ||
          got.replaced !== want.replaced || got.rnote !== want.rnote ||
          got.mask !== want.mask) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("Mismatch: expected assigned=%0d slot=%0d replaced=%0d note=%0d mask=%h",
                   want.assigned, want.aslot, want.replaced, want.rnote, want.mask);
          $display("          actual   assigned=%0d slot=%0d replaced=%0d note=%0d mask=%h",
                   got.assigned, got.aslot, got.replaced, got.rnote, got.mask);
        end
      end
    endfunction

    function int outstanding();
      return pending_outcomes.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic [1:0]                 operation;
  logic [pva_pkg::NOTE_W-1:0] note;
  logic [pva_pkg::VEL_W-1:0]  velocity;
  logic [pva_pkg::SLOT_W-1:0] slot;
  logic                       out_valid;
  logic                       out_stall;
  logic                       assigned;
  logic [pva_pkg::SLOT_W-1:0] assigned_slot;
  logic                       replaced;
  logic [pva_pkg::NOTE_W-1:0] replaced_note;
  logic [pva_pkg::MASK_W-1:0] release_mask;

  voice_alloc_tracker slot_table;
  int                 events_sent;
  int                 results_taken;
  int                 idle_cycles;
  bit                 steady_send;

  polyphonic_voice_allocator_top #(
    .NUM_SLOTS(SLOTS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .note         (note),
    .velocity     (velocity),
    .slot         (slot),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .assigned     (assigned),
    .assigned_slot(assigned_slot),
    .replaced     (replaced),
    .replaced_note(replaced_note),
    .release_mask (release_mask)
  );

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  // Mostly a small cluster of notes, so that retriggers and note offs find a match.
  function automatic logic [pva_pkg::NOTE_W-1:0] pick_note();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return pva_pkg::NOTE_W'($urandom_range(60, 67));
    else if (r < 80)
      return (r < 75) ? pva_pkg::NOTE_W'(0) : pva_pkg::NOTE_W'(127);
    else
      return pva_pkg::NOTE_W'($urandom_range(0, 127));
  endfunction

  function automatic logic [pva_pkg::VEL_W-1:0] pick_velocity();
    if ($urandom_range(0, 9) == 0)
      return '0;
    return pva_pkg::VEL_W'($urandom_range(1, 127));
  endfunction

  task automatic send_event(input logic [1:0] op, input logic [pva_pkg::NOTE_W-1:0] nt,
                            input logic [pva_pkg::VEL_W-1:0] vel,
                            input logic [pva_pkg::SLOT_W-1:0] sl);
    int gap;
    gap = steady_send ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    note      <= nt;
    velocity  <= vel;
    slot      <= sl;
    do @(posedge clk); while (in_stall);
    slot_table.note_event(op, nt, vel, sl);
    if (op != OP_UNUSED)
      events_sent++;
  endtask

  // Result side: a fresh stall length per item, runs without stalls, and two
  // long hold-offs during which the sender keeps offering items.
  initial begin
    int n;
    int fast_left;
    fast_left = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (results_taken == 100 || results_taken == 450) begin
        n = HOLD_CYCLES;
      end else if (fast_left > 0) begin
        n = 0;
        fast_left--;
      end else begin
        n = $urandom_range(0, 16);
        if ($urandom_range(0, 29) == 0)
          fast_left = 25;
      end
      if (n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      results_taken++;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      slot_table.check_result(outcome_t'{assigned, assigned_slot, replaced,
                                         replaced_note, release_mask});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int                         seg;
    int                         base;
    int                         step;
    int                         extra;
    int                         r;
    int                         goal;
    logic [pva_pkg::NOTE_W-1:0] nt;

    rst           = 1'b1;
    in_valid      = 1'b0;
    operation     = pva_pkg::OP_NOTE_ON;
    note          = '0;
    velocity      = '0;
    slot          = '0;
    out_stall     = 1'b0;
    events_sent   = 0;
    results_taken = 0;
    idle_cycles   = 0;
    steady_send   = 1'b0;
    slot_table    = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening: field extremes, retrigger, velocity zero as note off,
    // note off without a match, finishing a free slot and the unused code.
    send_event(pva_pkg::OP_NOTE_ON,    7'd0,   7'd127, 5'd0);
    send_event(pva_pkg::OP_NOTE_ON,    7'd127, 7'd1,   5'd31);
    send_event(pva_pkg::OP_NOTE_ON,    7'd0,   7'd64,  5'd0);
    send_event(pva_pkg::OP_NOTE_OFF,   7'd5,   7'd0,   5'd0);
    send_event(pva_pkg::OP_NOTE_OFF,   7'd127, 7'd127, 5'd31);
    send_event(pva_pkg::OP_NOTE_ON,    7'd0,   7'd0,   5'd0);
    send_event(pva_pkg::OP_VOICE_DONE, 7'd0,   7'd0,   5'd0);
    send_event(pva_pkg::OP_VOICE_DONE, 7'd127, 7'd127, 5'd0);
    send_event(pva_pkg::OP_VOICE_DONE, 7'd0,   7'd0,   5'd31);
    send_event(OP_UNUSED,              7'd127, 7'd127, 5'd31);
    send_event(OP_UNUSED,              7'd0,   7'd0,   5'd0);
    send_event(pva_pkg::OP_NOTE_ON,    7'd60,  7'd100, 5'd0);
    send_event(pva_pkg::OP_NOTE_ON,    7'd60,  7'd90,  5'd0);
    send_event(pva_pkg::OP_NOTE_OFF,   7'd60,  7'd10,  5'd0);
    send_event(pva_pkg::OP_NOTE_OFF,   7'd60,  7'd10,  5'd0);
    send_event(pva_pkg::OP_VOICE_DONE, 7'd60,  7'd1,   5'd1);
    send_event(pva_pkg::OP_NOTE_ON,    7'd61,  7'd127, 5'd0);

    goal = events_sent + RANDOM_ITEMS;
    while (events_sent < goal) begin
      steady_send = ($urandom_range(0, 3) == 0);
      seg = $urandom_range(0, 99);
      if (seg < 60) begin
        repeat ($urandom_range(20, 40)) begin
          r = $urandom_range(0, 99);
          if (r < 45)
            send_event(pva_pkg::OP_NOTE_ON, pick_note(), pick_velocity(),
                       5'($urandom_range(0, 31)));
          else if (r < 70)
            send_event(pva_pkg::OP_NOTE_OFF, pick_note(), 7'($urandom_range(0, 127)),
                       5'($urandom_range(0, 31)));
          else if (r < 93)
            send_event(pva_pkg::OP_VOICE_DONE, 7'($urandom_range(0, 127)),
                       7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
          else
            send_event(OP_UNUSED, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                       5'($urandom_range(0, 31)));
        end
      end else if (seg < 85) begin
        // Distinct notes fill every slot; the ones beyond that steal, and a
        // repeat of a held note releases its own slot and may take it back.
        base  = $urandom_range(0, 127);
        step  = 2 * $urandom_range(0, 63) + 1;
        extra = $urandom_range(1, 4);
        for (int k = 0; k < SLOTS + extra; k++) begin
          nt = pva_pkg::NOTE_W'((base + k * step) % 128);
          send_event(pva_pkg::OP_NOTE_ON, nt, 7'($urandom_range(1, 127)),
                     5'($urandom_range(0, 31)));
        end
        repeat (2) begin
          nt = pva_pkg::NOTE_W'((base + $urandom_range(0, SLOTS - 1) * step) % 128);
          send_event(pva_pkg::OP_NOTE_ON, nt, 7'($urandom_range(1, 127)),
                     5'($urandom_range(0, 31)));
        end
      end else begin
        for (int k = 0; k < SLOTS; k++) begin
          if ($urandom_range(0, 1) == 1)
            send_event(pva_pkg::OP_VOICE_DONE, 7'($urandom_range(0, 127)),
                       7'($urandom_range(0, 127)), pva_pkg::SLOT_W'(k));
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (slot_table.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (slot_table.errors == 0 && slot_table.outstanding() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
